@@ rtl/cemt_pkg.sv @@
// Shared types and constants for the cron entry match table.
// Holds the opcode and command codes, the mask and command word layouts and the queue size.
// Depends on nothing; every other file refers to it by scoped names.
package cemt_pkg;

    // Default number of table slots.
    localparam int ENTRY_SLOTS_DEF = 16;

    // Input opcodes.
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Command kinds that travel from the front end to the back end.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Field widths fixed by the interface.
    localparam int SLOT_W  = 4;
    localparam int INDEX_W = 4;

    // Command queue between the two halves.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // The five repeat masks of an entry, or the one-hot time of a tick.
    typedef struct packed {
        logic [59:0] minute;
        logic [23:0] hour;
        logic [30:0] day;
        logic [11:0] month;
        logic [6:0]  weekday;
    } t_masks;

    // One decoded command word.
    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        t_masks            masks;
    } t_cmd;

endpackage

@@ rtl/cron_entry_match_table_unit.sv @@
// Cron entry match table: input words are accepted one a cycle while the command queue has room.
// Write and remove are carried out as the back end pops them; a tick scans one slot a cycle
// through the entry memory's registered read port, unless a result word waits on an output stall.
// A tick holds the back end until its last result word is loaded into the output register.
// Reset is synchronous, active low, and clears all valid bits, the queue and the scan state.
module cron_entry_match_table_unit #(
    parameter int ENTRY_SLOTS = cemt_pkg::ENTRY_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  logic [cemt_pkg::SLOT_W-1:0]  i_slot,
    input  logic [59:0]                  i_minute_set,
    input  logic [23:0]                  i_hour_set,
    input  logic [30:0]                  i_day_set,
    input  logic [11:0]                  i_month_set,
    input  logic [6:0]                   i_weekday_set,
    input  logic [3:0]                   i_now_month,
    input  logic [4:0]                   i_now_day,
    input  logic [2:0]                   i_now_weekday,
    input  logic [4:0]                   i_now_hour,
    input  logic [5:0]                   i_now_minute,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cemt_pkg::INDEX_W-1:0] o_entry_index,
    output logic                         o_matched,
    output logic                         o_last
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    cemt_pkg::t_cmd cmd;
    cemt_pkg::t_cmd head;

    // A word is taken whenever the queue has room, including words that are dropped.
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    cemt_front #(
        .ENTRY_SLOTS(ENTRY_SLOTS)
    ) u_front (
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_minute_set (i_minute_set),
        .i_hour_set   (i_hour_set),
        .i_day_set    (i_day_set),
        .i_month_set  (i_month_set),
        .i_weekday_set(i_weekday_set),
        .i_now_month  (i_now_month),
        .i_now_day    (i_now_day),
        .i_now_weekday(i_now_weekday),
        .i_now_hour   (i_now_hour),
        .i_now_minute (i_now_minute),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    cemt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_head (head)
    );

    cemt_back #(
        .ENTRY_SLOTS(ENTRY_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_entry_index(o_entry_index),
        .o_matched    (o_matched),
        .o_last       (o_last)
    );

endmodule

@@ rtl/cemt_front.sv @@
// Front end of the cron entry match table: decodes each input word into a command.
// Drops unused opcodes and out-of-table slots, and turns a tick's time into one-hot masks.
// Depends on cemt_pkg.
module cemt_front #(
    parameter int ENTRY_SLOTS = cemt_pkg::ENTRY_SLOTS_DEF
) (
    input  logic                        i_accept,
    input  logic [1:0]                  i_opcode,
    input  logic [cemt_pkg::SLOT_W-1:0] i_slot,
    input  logic [59:0]                 i_minute_set,
    input  logic [23:0]                 i_hour_set,
    input  logic [30:0]                 i_day_set,
    input  logic [11:0]                 i_month_set,
    input  logic [6:0]                  i_weekday_set,
    input  logic [3:0]                  i_now_month,
    input  logic [4:0]                  i_now_day,
    input  logic [2:0]                  i_now_weekday,
    input  logic [4:0]                  i_now_hour,
    input  logic [5:0]                  i_now_minute,
    output logic                        o_push,
    output cemt_pkg::t_cmd              o_cmd
);

    logic             slot_in_table;
    logic             time_ok;
    cemt_pkg::t_masks tick_masks;
    cemt_pkg::t_masks write_masks;

    // A slot is usable only when it lies inside the table.
    assign slot_in_table = {3'b000, i_slot} < 7'(ENTRY_SLOTS);

    // A time field outside its range makes the whole tick match nothing.
    assign time_ok = (i_now_month >= 4'd1) && (i_now_month <= 4'd12) &&
                     (i_now_day >= 5'd1) && (i_now_weekday <= 3'd6) &&
                     (i_now_hour <= 5'd23) && (i_now_minute <= 6'd59);

    // One-hot time word, all zero when the time is invalid.
    always_comb begin
        tick_masks = '0;
        if (time_ok) begin
            tick_masks.minute  = 60'(1) << i_now_minute;
            tick_masks.hour    = 24'(1) << i_now_hour;
            tick_masks.day     = 31'(1) << (i_now_day - 5'd1);
            tick_masks.month   = 12'(1) << (i_now_month - 4'd1);
            tick_masks.weekday = 7'(1) << i_now_weekday;
        end
    end

    assign write_masks.minute  = i_minute_set;
    assign write_masks.hour    = i_hour_set;
    assign write_masks.day     = i_day_set;
    assign write_masks.month   = i_month_set;
    assign write_masks.weekday = i_weekday_set;

    // Opcode decoder: only meaningful words are pushed to the queue.
    always_comb begin
        o_push     = 1'b0;
        o_cmd.kind = cemt_pkg::CMD_WRITE;
        o_cmd.slot = i_slot;
        o_cmd.masks = write_masks;
        unique case (i_opcode)
            cemt_pkg::OP_WRITE: begin
                o_push     = i_accept && slot_in_table;
                o_cmd.kind = cemt_pkg::CMD_WRITE;
            end
            cemt_pkg::OP_REMOVE: begin
                o_push     = i_accept && slot_in_table;
                o_cmd.kind = cemt_pkg::CMD_REMOVE;
            end
            cemt_pkg::OP_TICK: begin
                o_push      = i_accept;
                o_cmd.kind  = cemt_pkg::CMD_TICK;
                o_cmd.masks = tick_masks;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/cemt_queue.sv @@
// Short command queue between the front end and the back end of the match table.
// A small first-in first-out store of decoded command words.
// Depends on cemt_pkg.
module cemt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cemt_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output cemt_pkg::t_cmd o_head
);

    cemt_pkg::t_cmd                   r_store [cemt_pkg::QUEUE_DEPTH];
    logic [cemt_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [cemt_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [cemt_pkg::QUEUE_CNT_W-1:0] r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = r_count == cemt_pkg::QUEUE_CNT_W'(cemt_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_store[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/cemt_back.sv @@
// Back end of the cron entry match table: the entry memory, the valid bits and the tick scan.
// Executes queued commands in order and drives the registered result word.
// Depends on cemt_pkg.
module cemt_back #(
    parameter int ENTRY_SLOTS = cemt_pkg::ENTRY_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  cemt_pkg::t_cmd               i_head,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cemt_pkg::INDEX_W-1:0] o_entry_index,
    output logic                         o_matched,
    output logic                         o_last
);

    localparam int IDX_W = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
    localparam int CNT_W = $clog2(ENTRY_SLOTS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    cemt_pkg::t_masks             r_mem [ENTRY_SLOTS];
    logic [ENTRY_SLOTS-1:0]       r_valid;
    logic                         r_state;
    logic [CNT_W-1:0]             r_scan_cnt;
    cemt_pkg::t_masks             r_tick;
    // Compare stage, fed by the registered memory read.
    logic                         r_q_vld;
    logic                         r_q_ok;
    logic [IDX_W-1:0]             r_q_idx;
    cemt_pkg::t_masks             r_rd;
    // The most recent match, held back until it is known whether it is the last one.
    logic                         r_pend_vld;
    logic [cemt_pkg::INDEX_W-1:0] r_pend_idx;
    // Output register.
    logic                         r_out_vld;
    logic [cemt_pkg::INDEX_W-1:0] r_out_idx;
    logic                         r_out_matched;
    logic                         r_out_last;

    logic                         can_emit;
    logic                         hit;
    logic                         emit_mid;
    logic                         q_take;
    logic                         issue_done;
    logic                         issue;
    logic                         finish;
    logic                         out_load;
    logic [IDX_W-1:0]             rd_idx;
    logic [IDX_W-1:0]             cmd_idx;
    logic [cemt_pkg::INDEX_W-1:0] n_out_idx;
    logic                         n_out_matched;
    logic                         n_out_last;

    assign cmd_idx = IDX_W'(i_head.slot);
    assign rd_idx  = r_scan_cnt[IDX_W-1:0];
    assign o_pop   = (r_state == ST_IDLE) && !i_empty;

    // An entry matches when every one of its masks covers the tick's time.
    assign hit = r_q_ok &&
                 (|(r_rd.minute  & r_tick.minute)) &&
                 (|(r_rd.hour    & r_tick.hour)) &&
                 (|(r_rd.day     & r_tick.day)) &&
                 (|(r_rd.month   & r_tick.month)) &&
                 (|(r_rd.weekday & r_tick.weekday));

    // Scan flow control: the compare stage only stalls when it must push out a word.
    assign can_emit   = !r_out_vld || !i_out_stall;
    assign emit_mid   = r_q_vld && hit && r_pend_vld;
    assign q_take     = r_q_vld && (!emit_mid || can_emit);
    assign issue_done = r_scan_cnt == CNT_W'(ENTRY_SLOTS);
    assign issue      = (r_state == ST_SCAN) && !issue_done && (!r_q_vld || q_take);
    assign finish     = (r_state == ST_SCAN) && issue_done && !r_q_vld && can_emit;
    assign out_load   = (emit_mid && q_take) || finish;

    // Result word: an earlier match, the final match, or the no-match word.
    always_comb begin
        n_out_idx     = r_pend_idx;
        n_out_matched = 1'b1;
        n_out_last    = 1'b0;
        if (finish) begin
            n_out_last = 1'b1;
            if (!r_pend_vld) begin
                n_out_idx     = '0;
                n_out_matched = 1'b0;
            end
        end
    end

    // Control state, valid bits and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_scan_cnt <= '0;
            r_q_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_head.kind)
                            cemt_pkg::CMD_WRITE: begin
                                r_valid[cmd_idx] <= 1'b1;
                            end
                            cemt_pkg::CMD_REMOVE: begin
                                r_valid[cmd_idx] <= 1'b0;
                            end
                            cemt_pkg::CMD_TICK: begin
                                r_state    <= ST_SCAN;
                                r_scan_cnt <= '0;
                                r_pend_vld <= 1'b0;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_scan_cnt <= r_scan_cnt + 1'b1;
                    end
                    if (issue) begin
                        r_q_vld <= 1'b1;
                    end else if (q_take) begin
                        r_q_vld <= 1'b0;
                    end
                    if (q_take && hit) begin
                        r_pend_vld <= 1'b1;
                    end
                    if (finish) begin
                        r_pend_vld <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Entry memory: written from the queue head, read one slot a cycle during a scan unless the compare stage stalls.
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == cemt_pkg::CMD_WRITE)) begin
            r_mem[cmd_idx] <= i_head.masks;
        end
        if (issue) begin
            r_rd    <= r_mem[rd_idx];
            r_q_ok  <= r_valid[rd_idx];
            r_q_idx <= rd_idx;
        end
    end

    // Tick time, pending match and result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == cemt_pkg::CMD_TICK)) begin
            r_tick <= i_head.masks;
        end
        if (q_take && hit) begin
            r_pend_idx <= cemt_pkg::INDEX_W'(r_q_idx);
        end
        if (out_load) begin
            r_out_idx     <= n_out_idx;
            r_out_matched <= n_out_matched;
            r_out_last    <= n_out_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_entry_index = r_out_idx;
    assign o_matched     = r_out_matched;
    assign o_last        = r_out_last;

endmodule

@@ test/cron_entry_match_table_unit_test.sv @@
// Self-checking testbench for cron_entry_match_table_unit: a short table of directed words,
// then random write, remove, tick and unused-opcode words, checked against a cycle-free match predictor.
// Depends on rtl/cemt_pkg.sv and rtl/cron_entry_match_table_unit.sv.
module cron_entry_match_table_unit_test;

    localparam int ENTRY_SLOTS   = cemt_pkg::ENTRY_SLOTS_DEF;
    localparam int RANDOM_WORDS  = 120;
    localparam int QUIET_WORDS   = 30;
    localparam int SETTLE_CYCLES = 4 * (ENTRY_SLOTS + 3);
    localparam int WATCHDOG_MAX  = 2000;

    // Opcode 3 has no meaning; the block must drop it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Calendar time carried by a tick word.
    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
    } t_now;

    // One input word, laid out field by field.
    typedef struct packed {
        logic [1:0]                    opcode;
        logic [cemt_pkg::SLOT_W-1:0]   slot;
        cemt_pkg::t_masks              masks;
        t_now                          now;
    } t_word;

    // One result word.
    typedef struct packed {
        logic [cemt_pkg::INDEX_W-1:0]  index;
        logic                          matched;
        logic                          last;
    } t_result;

    // A directed step: the word, and a result typed in by hand where it is obvious.
    typedef struct packed {
        t_word   w;
        logic    typed;
        t_result res;
    } t_row;

    localparam t_now T_MIN = {4'd1, 5'd1, 3'd0, 5'd0, 6'd0};
    localparam t_now T_MAX = {4'd12, 5'd31, 3'd6, 5'd23, 6'd59};

    localparam cemt_pkg::t_masks MASKS_ALL  = '1;
    localparam cemt_pkg::t_masks MASKS_NONE = '0;
    localparam cemt_pkg::t_masks MASKS_MIN0 =
        {60'd1, 24'hFFFFFF, 31'h7FFFFFFF, 12'hFFF, 7'h7F};

    localparam t_result RES_NONE  = '0;
    localparam t_result NO_MATCH  = {4'd0, 1'b0, 1'b1};
    localparam t_result HIT0_LAST = {4'd0, 1'b1, 1'b1};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [1:0]                    i_opcode;
    logic [cemt_pkg::SLOT_W-1:0]   i_slot;
    logic [59:0]                   i_minute_set;
    logic [23:0]                   i_hour_set;
    logic [30:0]                   i_day_set;
    logic [11:0]                   i_month_set;
    logic [6:0]                    i_weekday_set;
    logic [3:0]                    i_now_month;
    logic [4:0]                    i_now_day;
    logic [2:0]                    i_now_weekday;
    logic [4:0]                    i_now_hour;
    logic [5:0]                    i_now_minute;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [cemt_pkg::INDEX_W-1:0]  o_entry_index;
    logic                          o_matched;
    logic                          o_last;

    // Predictor state: a shadow copy of the cron table.
    cemt_pkg::t_masks        entry_masks [ENTRY_SLOTS];
    logic [ENTRY_SLOTS-1:0]  entry_live;

    t_result  expected_results [$];
    t_row     plan [$];
    int       fault_count = 0;
    int       word_count  = 0;
    int       idle_cycles = 0;
    bit       quiet_tail  = 1'b0;

    cron_entry_match_table_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_slot        (i_slot),
        .i_minute_set  (i_minute_set),
        .i_hour_set    (i_hour_set),
        .i_day_set     (i_day_set),
        .i_month_set   (i_month_set),
        .i_weekday_set (i_weekday_set),
        .i_now_month   (i_now_month),
        .i_now_day     (i_now_day),
        .i_now_weekday (i_now_weekday),
        .i_now_hour    (i_now_hour),
        .i_now_minute  (i_now_minute),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_index (o_entry_index),
        .o_matched     (o_matched),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Applies one accepted word to the shadow table and queues the results a tick should give.
    function automatic void predict_word(input t_word w);
        logic [ENTRY_SLOTS-1:0] hits;
        hits = '0;
        case (w.opcode)
            cemt_pkg::OP_WRITE: begin
                entry_masks[w.slot] = w.masks;
                entry_live[w.slot]  = 1'b1;
            end
            cemt_pkg::OP_REMOVE: begin
                entry_live[w.slot] = 1'b0;
            end
            cemt_pkg::OP_TICK: begin
                // A time with any field out of range matches nothing.
                if (w.now.month >= 4'd1 && w.now.month <= 4'd12 && w.now.day >= 5'd1 &&
                        w.now.weekday <= 3'd6 && w.now.hour <= 5'd23 &&
                        w.now.minute <= 6'd59) begin
                    for (int i = 0; i < ENTRY_SLOTS; i++) begin
                        hits[i] = entry_live[i] &&
                                  entry_masks[i].month[w.now.month - 4'd1] &&
                                  entry_masks[i].day[w.now.day - 5'd1] &&
                                  entry_masks[i].weekday[w.now.weekday] &&
                                  entry_masks[i].hour[w.now.hour] &&
                                  entry_masks[i].minute[w.now.minute];
                    end
                end
                if (hits == '0) begin
                    expected_results.push_back(NO_MATCH);
                end else begin
                    for (int i = 0; i < ENTRY_SLOTS; i++) begin
                        if (hits[i])
                            expected_results.push_back({4'(i), 1'b1, (hits >> (i + 1)) == '0});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic cemt_pkg::t_masks random_masks();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[133:0];
    endfunction

    // Any word at all: every field random, opcode 3 and out-of-range times included.
    function automatic t_word random_word();
        t_word w;
        w.opcode = 2'($urandom_range(0, 3));
        w.slot   = 4'($urandom);
        w.masks  = random_masks();
        w.now    = 23'($urandom);
        return w;
    endfunction

    function automatic t_now random_time();
        t_now t;
        t.month   = 4'($urandom_range(1, 12));
        t.day     = 5'($urandom_range(1, 31));
        t.weekday = 3'($urandom_range(0, 6));
        t.hour    = 5'($urandom_range(0, 23));
        t.minute  = 6'($urandom_range(0, 59));
        return t;
    endfunction

    // Masks that contain the given time, with the odd near miss on a single field.
    function automatic cemt_pkg::t_masks masks_for(input t_now t);
        cemt_pkg::t_masks m;
        m = random_masks();
        if ($urandom_range(0, 1) == 0)
            m = m & random_masks();
        m.minute[t.minute]         = 1'b1;
        m.hour[t.hour]             = 1'b1;
        m.day[t.day - 5'd1]        = 1'b1;
        m.month[t.month - 4'd1]    = 1'b1;
        m.weekday[t.weekday]       = 1'b1;
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
                0: m.minute[t.minute]      = 1'b0;
                1: m.hour[t.hour]          = 1'b0;
                2: m.day[t.day - 5'd1]     = 1'b0;
                3: m.month[t.month - 4'd1] = 1'b0;
                default: m.weekday[t.weekday] = 1'b0;
            endcase
        end
        return m;
    endfunction

    // Drops valid for a burst of cycles.
    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Offers one word, waits for it to be taken, then records what it should produce.
    task automatic send_word(input t_word w, input logic typed, input t_result res);
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_opcode      <= w.opcode;
        i_slot        <= w.slot;
        i_minute_set  <= w.masks.minute;
        i_hour_set    <= w.masks.hour;
        i_day_set     <= w.masks.day;
        i_month_set   <= w.masks.month;
        i_weekday_set <= w.masks.weekday;
        i_now_month   <= w.now.month;
        i_now_day     <= w.now.day;
        i_now_weekday <= w.now.weekday;
        i_now_hour    <= w.now.hour;
        i_now_minute  <= w.now.minute;
        do @(posedge i_clk); while (o_in_stall);
        // Hand-typed rows are all ticks, so they leave the shadow table alone.
        if (typed)
            expected_results.push_back(res);
        else
            predict_word(w);
        if (w.opcode != OP_UNUSED)
            word_count++;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
            pause_sender($urandom_range(1, 12));
    endtask

    task automatic write_entry(input int slot, input t_now t);
        t_word w;
        w        = random_word();
        w.opcode = cemt_pkg::OP_WRITE;
        w.slot   = 4'(slot);
        w.masks  = masks_for(t);
        send_word(w, 1'b0, RES_NONE);
    endtask

    task automatic tick_at(input t_now t);
        t_word w;
        w        = random_word();
        w.opcode = cemt_pkg::OP_TICK;
        w.now    = t;
        send_word(w, 1'b0, RES_NONE);
    endtask

    // Holds the sender off until every expected result word has come back.
    task automatic await_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall bursts, with stretches of none, and none at all in the tail.
    initial begin
        int burst;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (quiet_tail) begin
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 12);
                i_out_stall <= 1'b1;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // Result checker: each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result word: index %0d matched %0d last %0d",
                             o_entry_index, o_matched, o_last);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_entry_index !== exp_res.index || o_matched !== exp_res.matched ||
                        o_last !== exp_res.last) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"result mismatch: expected index %0d matched %0d last %0d,",
                                  " got index %0d matched %0d last %0d"},
                                 exp_res.index, exp_res.matched, exp_res.last,
                                 o_entry_index, o_matched, o_last);
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("cron_entry_match_table_unit_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_now hot;
        int   round_kind;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = cemt_pkg::OP_WRITE;
        i_slot        = '0;
        i_minute_set  = '0;
        i_hour_set    = '0;
        i_day_set     = '0;
        i_month_set   = '0;
        i_weekday_set = '0;
        i_now_month   = '0;
        i_now_day     = '0;
        i_now_weekday = '0;
        i_now_hour    = '0;
        i_now_minute  = '0;
        entry_live    = '0;

        // Empty table after reset: a valid tick finds nothing.
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, T_MIN, 1'b1, NO_MATCH});
        // A catch-all entry in slot 0 fires at both ends of the calendar.
        plan.push_back({cemt_pkg::OP_WRITE, 4'd0, MASKS_ALL, T_MAX, 1'b0, RES_NONE});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_NONE, T_MAX, 1'b1, HIT0_LAST});
        plan.push_back({cemt_pkg::OP_TICK, 4'd9, MASKS_NONE, T_MIN, 1'b1, HIT0_LAST});
        // Each out-of-range time field misses even the catch-all entry.
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd0, 5'd1, 3'd0, 5'd0, 6'd0},
                        1'b1, NO_MATCH});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd13, 5'd1, 3'd0, 5'd0, 6'd0},
                        1'b1, NO_MATCH});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd15, 5'd31, 3'd6, 5'd23, 6'd59},
                        1'b1, NO_MATCH});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd1, 5'd0, 3'd0, 5'd0, 6'd0},
                        1'b1, NO_MATCH});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd1, 5'd1, 3'd7, 5'd0, 6'd0},
                        1'b1, NO_MATCH});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd1, 5'd1, 3'd0, 5'd24, 6'd0},
                        1'b1, NO_MATCH});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd12, 5'd31, 3'd6, 5'd31, 6'd59},
                        1'b1, NO_MATCH});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd1, 5'd1, 3'd0, 5'd0, 6'd60},
                        1'b1, NO_MATCH});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, {4'd12, 5'd31, 3'd6, 5'd23, 6'd63},
                        1'b1, NO_MATCH});
        // The unused opcode is dropped without a result.
        plan.push_back({OP_UNUSED, 4'd5, MASKS_ALL, T_MIN, 1'b0, RES_NONE});
        // A second catch-all in the top slot: both are reported, lowest slot first.
        plan.push_back({cemt_pkg::OP_WRITE, 4'd15, MASKS_ALL, T_MIN, 1'b0, RES_NONE});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_ALL, T_MAX, 1'b0, RES_NONE});
        // Writing over a live slot replaces its masks: slot 15 now fires on minute 0 only.
        plan.push_back({cemt_pkg::OP_WRITE, 4'd15, MASKS_MIN0, T_MAX, 1'b0, RES_NONE});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_NONE, T_MAX, 1'b0, RES_NONE});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_NONE, T_MIN, 1'b0, RES_NONE});
        // Removing slot 0 twice: the second remove hits a dead slot and changes nothing.
        plan.push_back({cemt_pkg::OP_REMOVE, 4'd0, MASKS_ALL, T_MAX, 1'b0, RES_NONE});
        plan.push_back({cemt_pkg::OP_REMOVE, 4'd0, MASKS_ALL, T_MAX, 1'b0, RES_NONE});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_NONE, T_MIN, 1'b0, RES_NONE});
        // Empty masks never match.
        plan.push_back({cemt_pkg::OP_WRITE, 4'd7, MASKS_NONE, T_MIN, 1'b0, RES_NONE});
        plan.push_back({cemt_pkg::OP_TICK, 4'd0, MASKS_NONE, T_MAX, 1'b0, RES_NONE});

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k])
            send_word(plan[k].w, plan[k].typed, plan[k].res);
        await_all_results();

        // Random rounds: mostly entries written around one time and a tick at that time.
        while (word_count < plan.size() + RANDOM_WORDS) begin
            if (word_count >= plan.size() + RANDOM_WORDS - QUIET_WORDS)
                quiet_tail = 1'b1;
            hot = random_time();
            round_kind = $urandom_range(0, 11);
            if (round_kind == 0) begin
                // Every slot written around the same time, which can give the longest result burst.
                for (int s = 0; s < ENTRY_SLOTS; s++)
                    write_entry(s, hot);
                tick_at(hot);
            end else if (round_kind <= 8) begin
                repeat ($urandom_range(1, 4))
                    write_entry($urandom_range(0, ENTRY_SLOTS - 1), hot);
                if ($urandom_range(0, 1) == 0)
                    send_word({cemt_pkg::OP_REMOVE, 4'($urandom), random_masks(),
                               23'($urandom)}, 1'b0, RES_NONE);
                tick_at(hot);
                if ($urandom_range(0, 2) == 0)
                    tick_at(random_time());
            end else begin
                // Noise: words of any kind with every field random.
                repeat ($urandom_range(1, 4))
                    send_word(random_word(), 1'b0, RES_NONE);
            end
            if (!quiet_tail && $urandom_range(0, 5) == 0)
                await_all_results();
        end

        await_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && expected_results.size() == 0)
            $display("cron_entry_match_table_unit_test: clean");
        else
            $display("cron_entry_match_table_unit_test: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cemt_pkg.sv
rtl/cemt_front.sv
rtl/cemt_queue.sv
rtl/cemt_back.sv
rtl/cron_entry_match_table_unit.sv
test/cron_entry_match_table_unit_test.sv
